// ===== rtl/core/pwm_range_spike_filter_averager_assert.svh =====
// Assertion macros used by the checker module of the range filter.
// Each macro builds one labelled concurrent assertion on the rising edge
// of clk, switched off while arst_n is low.
`ifndef PWM_RANGE_SPIKE_FILTER_AVERAGER_ASSERT_SVH
`define PWM_RANGE_SPIKE_FILTER_AVERAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRSFA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRSFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/prsfa_pkg.sv =====
// ----------------------------------------------------------------------------
// prsfa_pkg
// Widths, constants and word types of the pulse-width range filter.
// ----------------------------------------------------------------------------
package prsfa_pkg;

	// Largest number of samples summed between two ticks.
	localparam int MAX_BATCH = 32;

	// Field widths.
	localparam int PW_W     = 16;
	localparam int SCALE_W  = 16;
	localparam int OFF_W    = 16;
	localparam int SETTLE_W = 15;
	localparam int TIME_W   = 32;
	localparam int DIST_W   = 24;
	localparam int STATUS_W = 2;
	localparam int FRAC_W   = 8;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Derived widths of the sample count, the running sum and the product.
	localparam int CNT_W  = $clog2(MAX_BATCH + 1);
	localparam int SUM_W  = DIST_W + CNT_W;
	localparam int PROD_W = PW_W + SCALE_W;

	// Divide-by-ten with rounding half up, giving 0.1 * pulse * scale.
	localparam int DIV_TEN = 10;
	localparam int ROUND   = 5;
	localparam int REM_W   = $clog2(DIV_TEN);

	// Spike limit of 100 cm in Q8, and the timer limits.
	localparam int JUMP_Q8 = 25600;
	localparam logic [TIME_W-1:0] NODATA_US = 32'd200000;
	localparam logic [TIME_W-1:0] RESET_MS  = 32'd500;

	// Register reset values.
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd768;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_PIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd3;

	// Request kinds.
	localparam logic REQ_PULSE = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_NOT_CONNECTED = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_DATA       = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FRESH         = 2'd2;

	// Input word.
	typedef struct packed {
		logic              req_type;
		logic [PW_W-1:0]   pulse_width_us;
		logic [TIME_W-1:0] pulse_time_us;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] now_us;
		logic              above_powersave;
		logic              sensor_present;
	} req_t;

	// Result word.
	typedef struct packed {
		logic signed [DIST_W-1:0] distance_q8;
		logic                     new_reading;
		logic [PW_W-1:0]          raw_pulse_us;
		logic [STATUS_W-1:0]      status_code;
		logic                     stop_pin_level;
		logic                     reset_request;
	} rsp_t;

	// Operands of the distance conversion.
	typedef struct packed {
		logic [PW_W-1:0]         pulse_width_us;
		logic [SCALE_W-1:0]      scale_q8;
		logic signed [OFF_W-1:0] offset_cm;
	} dist_req_t;

	// Operands of the averaging division.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
	} avg_req_t;

endpackage

// ===== rtl/core/prsfa_dist.sv =====
// ----------------------------------------------------------------------------
// prsfa_dist
// Bit-serial distance conversion: pulse * scale by shift and add, rounding,
// a restoring division by ten one bit a cycle, then offset and saturation.
// ----------------------------------------------------------------------------
module prsfa_dist (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  prsfa_pkg::dist_req_t            req,
	output logic                            done,
	output logic signed [prsfa_pkg::DIST_W-1:0] dist_q8
);

	localparam int STEP_W = $clog2(prsfa_pkg::PROD_W);
	localparam int WIDE_W = prsfa_pkg::PROD_W + 2;
	localparam int EXT_W  = WIDE_W - prsfa_pkg::OFF_W - prsfa_pkg::FRAC_W;
	localparam logic signed [WIDE_W-1:0] D_MAX_W = WIDE_W'(2 ** (prsfa_pkg::DIST_W - 1) - 1);
	localparam logic signed [WIDE_W-1:0] D_MIN_W = -D_MAX_W - WIDE_W'(1);

	typedef enum logic [4:0] {
		DS_IDLE = 5'b00001,
		DS_MUL  = 5'b00010,
		DS_RND  = 5'b00100,
		DS_DIV  = 5'b01000,
		DS_FIN  = 5'b10000
	} dist_state_t;

	dist_state_t                       state_q;
	logic [STEP_W-1:0]                 step_q;
	logic [prsfa_pkg::PROD_W-1:0]      prod_q;
	logic [prsfa_pkg::SCALE_W-1:0]     mcand_q;
	logic signed [prsfa_pkg::OFF_W-1:0] off_q;
	logic [prsfa_pkg::REM_W-1:0]       rem_q;
	logic signed [prsfa_pkg::DIST_W-1:0] dist_q;
	logic                              done_q;

	logic [prsfa_pkg::SCALE_W:0]       mul_sum;
	logic [prsfa_pkg::REM_W:0]         rem_sh;
	logic                              rem_ge;
	logic [prsfa_pkg::REM_W:0]         rem_sub;
	logic signed [WIDE_W-1:0]          q_ext;
	logic signed [WIDE_W-1:0]          off_ext;
	logic signed [WIDE_W-1:0]          d_wide;

	// One multiply step: add the multiplicand to the upper half when the low bit is set.
	always_comb begin
		mul_sum = {1'b0, prod_q[prsfa_pkg::PROD_W-1:prsfa_pkg::PW_W]}
			+ (prod_q[0] ? {1'b0, mcand_q} : '0);
	end

	// One division step: the remainder takes the next dividend bit.
	always_comb begin
		rem_sh  = {rem_q, prod_q[prsfa_pkg::PROD_W-1]};
		rem_ge  = rem_sh >= (prsfa_pkg::REM_W + 1)'(prsfa_pkg::DIV_TEN);
		rem_sub = rem_sh - (prsfa_pkg::REM_W + 1)'(prsfa_pkg::DIV_TEN);
	end

	// Offset in Q8 added to the quotient, then clamped to the distance range.
	always_comb begin
		q_ext   = {2'b00, prod_q};
		off_ext = {{EXT_W{off_q[prsfa_pkg::OFF_W-1]}}, off_q, {prsfa_pkg::FRAC_W{1'b0}}};
		d_wide  = q_ext + off_ext;
	end

	// Sequencer over the multiply, round, divide and finish phases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DS_IDLE: begin
					if (start) begin
						step_q  <= '0;
						state_q <= DS_MUL;
					end
				end
				DS_MUL: begin
					if (step_q == STEP_W'(prsfa_pkg::PW_W - 1)) begin
						step_q  <= '0;
						state_q <= DS_RND;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				DS_RND: begin
					state_q <= DS_DIV;
				end
				DS_DIV: begin
					if (step_q == STEP_W'(prsfa_pkg::PROD_W - 1)) begin
						step_q  <= '0;
						state_q <= DS_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				DS_FIN: begin
					done_q  <= 1'b1;
					state_q <= DS_IDLE;
				end
				default: begin
					state_q <= DS_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			DS_IDLE: begin
				if (start) begin
					prod_q  <= {{prsfa_pkg::SCALE_W{1'b0}}, req.pulse_width_us};
					mcand_q <= req.scale_q8;
					off_q   <= req.offset_cm;
					rem_q   <= '0;
				end
			end
			DS_MUL: begin
				prod_q <= {mul_sum, prod_q[prsfa_pkg::PW_W-1:1]};
			end
			DS_RND: begin
				prod_q <= prod_q + prsfa_pkg::PROD_W'(prsfa_pkg::ROUND);
			end
			DS_DIV: begin
				rem_q  <= rem_ge ? rem_sub[prsfa_pkg::REM_W-1:0] : rem_sh[prsfa_pkg::REM_W-1:0];
				prod_q <= {prod_q[prsfa_pkg::PROD_W-2:0], rem_ge};
			end
			DS_FIN: begin
				priority if (d_wide > D_MAX_W) begin
					dist_q <= D_MAX_W[prsfa_pkg::DIST_W-1:0];
				end else if (d_wide < D_MIN_W) begin
					dist_q <= D_MIN_W[prsfa_pkg::DIST_W-1:0];
				end else begin
					dist_q <= d_wide[prsfa_pkg::DIST_W-1:0];
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done    = done_q;
	assign dist_q8 = dist_q;

endmodule

// ===== rtl/core/prsfa_avg_div.sv =====
// ----------------------------------------------------------------------------
// prsfa_avg_div
// Bit-serial signed division of the sample sum by the sample count, one
// quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module prsfa_avg_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  prsfa_pkg::avg_req_t                 req,
	output logic                                done,
	output logic signed [prsfa_pkg::DIST_W-1:0] avg_q8
);

	localparam int STEP_W = $clog2(prsfa_pkg::SUM_W);

	typedef enum logic [2:0] {
		AS_IDLE = 3'b001,
		AS_RUN  = 3'b010,
		AS_FIN  = 3'b100
	} avg_state_t;

	avg_state_t                        state_q;
	logic [STEP_W-1:0]                 step_q;
	logic [prsfa_pkg::SUM_W-1:0]       mag_q;
	logic [prsfa_pkg::CNT_W-1:0]       div_q;
	logic [prsfa_pkg::CNT_W-1:0]       rem_q;
	logic                              neg_q;
	logic signed [prsfa_pkg::DIST_W-1:0] avg_q;
	logic                              done_q;

	logic [prsfa_pkg::CNT_W:0]         rem_sh;
	logic                              rem_ge;
	logic [prsfa_pkg::CNT_W:0]         rem_sub;
	logic [prsfa_pkg::SUM_W-1:0]       res;

	// One restoring step against the count.
	always_comb begin
		rem_sh  = {rem_q, mag_q[prsfa_pkg::SUM_W-1]};
		rem_ge  = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
		res     = neg_q ? (~mag_q + 1'b1) : mag_q;
	end

	// Step sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AS_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				AS_IDLE: begin
					if (start) begin
						step_q  <= '0;
						state_q <= AS_RUN;
					end
				end
				AS_RUN: begin
					if (step_q == STEP_W'(prsfa_pkg::SUM_W - 1)) begin
						state_q <= AS_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				AS_FIN: begin
					done_q  <= 1'b1;
					state_q <= AS_IDLE;
				end
				default: begin
					state_q <= AS_IDLE;
				end
			endcase
		end
	end

	// Magnitude, remainder and sign registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			AS_IDLE: begin
				if (start) begin
					neg_q <= req.sum[prsfa_pkg::SUM_W-1];
					mag_q <= req.sum[prsfa_pkg::SUM_W-1] ? prsfa_pkg::SUM_W'(-req.sum)
						: prsfa_pkg::SUM_W'(req.sum);
					div_q <= req.count;
					rem_q <= '0;
				end
			end
			AS_RUN: begin
				rem_q <= rem_ge ? rem_sub[prsfa_pkg::CNT_W-1:0] : rem_sh[prsfa_pkg::CNT_W-1:0];
				mag_q <= {mag_q[prsfa_pkg::SUM_W-2:0], rem_ge};
			end
			AS_FIN: begin
				avg_q <= res[prsfa_pkg::DIST_W-1:0];
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done   = done_q;
	assign avg_q8 = avg_q;

endmodule

// ===== rtl/core/pwm_range_spike_filter_averager.sv =====
// ----------------------------------------------------------------------------
// pwm_range_spike_filter_averager
// A pulse word runs through the bit-serial conversion unit (multiply, round, divide
// by ten, clamp) and then one filter update. A tick averages through the 30-step
// serial divider when samples are held, and its result waits while the output is
// stalled; one word is in work at a time.
// Reset (arst_n low) restores the configuration, filter, timer and sequencer state at once.
// ----------------------------------------------------------------------------
module pwm_range_spike_filter_averager (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  prsfa_pkg::req_t                     req_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output prsfa_pkg::rsp_t                     rsp_data,
	input  logic                                cfg_we,
	input  logic [prsfa_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [prsfa_pkg::CFG_W-1:0]         cfg_data
);

	localparam int DIFF_W = prsfa_pkg::DIST_W + 1;
	localparam logic signed [DIFF_W-1:0] JUMP_POS = DIFF_W'(prsfa_pkg::JUMP_Q8);
	localparam logic signed [DIFF_W-1:0] JUMP_NEG = -JUMP_POS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PWAIT = 5'b00010,
		S_TICK  = 5'b00100,
		S_TDIV  = 5'b01000,
		S_TOUT  = 5'b10000
	} top_state_t;

	top_state_t state_q;

	// Configuration registers.
	logic [prsfa_pkg::SCALE_W-1:0]       scale_q;
	logic signed [prsfa_pkg::OFF_W-1:0]  offset_q;
	logic                                stop_en_q;
	logic [prsfa_pkg::SETTLE_W-1:0]      settle_q;

	// Filter and timer state.
	logic signed [prsfa_pkg::DIST_W-1:0] prev_q;
	logic [1:0]                          good_run_q;
	logic signed [prsfa_pkg::SUM_W-1:0]  sum_q;
	logic [prsfa_pkg::CNT_W-1:0]         count_q;
	logic [prsfa_pkg::TIME_W-1:0]        last_sample_q;
	logic [prsfa_pkg::TIME_W-1:0]        last_pulse_q;
	logic [prsfa_pkg::TIME_W-1:0]        dis_start_q;
	logic                                disabled_q;
	logic                                pin_q;
	logic [prsfa_pkg::PW_W-1:0]          last_raw_q;
	logic signed [prsfa_pkg::DIST_W-1:0] held_q;
	logic [prsfa_pkg::STATUS_W-1:0]      status_q;
	logic                                fresh_q;
	logic                                rst_q;

	// Word in work and result register.
	prsfa_pkg::req_t                     item_q;
	prsfa_pkg::rsp_t                     rsp_q;
	logic                                rsp_valid_q;

	logic                                req_take;
	logic                                dist_start;
	prsfa_pkg::dist_req_t                dist_req;
	logic                                dist_done;
	logic signed [prsfa_pkg::DIST_W-1:0] dist_q8;
	logic                                avg_start;
	prsfa_pkg::avg_req_t                 avg_req;
	logic                                avg_done;
	logic signed [prsfa_pkg::DIST_W-1:0] avg_q8;

	logic signed [DIFF_W-1:0]            diff;
	logic                                jump;
	logic                                tick_live;
	logic                                powersave;
	logic                                nodata;
	logic                                reset_due;
	logic                                settle_due;
	logic                                rsp_load;

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;

	// A present pulse starts the conversion as it is accepted.
	assign dist_start = req_take && (req_data.req_type == prsfa_pkg::REQ_PULSE)
		&& req_data.sensor_present;
	always_comb begin
		dist_req.pulse_width_us = req_data.pulse_width_us;
		dist_req.scale_q8       = scale_q;
		dist_req.offset_cm      = offset_q;
	end

	prsfa_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dist_start),
		.req     (dist_req),
		.done    (dist_done),
		.dist_q8 (dist_q8)
	);

	// Spike test against the previous sample.
	always_comb begin
		diff = {dist_q8[prsfa_pkg::DIST_W-1], dist_q8} - {prev_q[prsfa_pkg::DIST_W-1], prev_q};
		jump = (diff > JUMP_POS) || (diff < JUMP_NEG);
	end

	// Tick decisions, taken from the word held in item_q.
	always_comb begin
		powersave  = stop_en_q && item_q.above_powersave;
		tick_live  = item_q.sensor_present && !powersave;
		nodata     = (item_q.now_us - last_sample_q) >= prsfa_pkg::NODATA_US;
		reset_due  = ((item_q.now_ms - last_pulse_q) > prsfa_pkg::RESET_MS) && !disabled_q;
		settle_due = stop_en_q && disabled_q
			&& ((item_q.now_ms - dis_start_q) > prsfa_pkg::TIME_W'(settle_q));
	end

	assign avg_start = (state_q == S_TICK) && tick_live && (count_q != '0);
	always_comb begin
		avg_req.sum   = sum_q;
		avg_req.count = count_q;
	end

	prsfa_avg_div u_avg_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (avg_start),
		.req    (avg_req),
		.done   (avg_done),
		.avg_q8 (avg_q8)
	);

	assign rsp_load = (state_q == S_TOUT) && (!rsp_valid_q || !rsp_stall);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= prsfa_pkg::SCALE_RESET;
			offset_q  <= '0;
			stop_en_q <= 1'b0;
			settle_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				prsfa_pkg::CFG_SCALE:    scale_q   <= cfg_data[prsfa_pkg::SCALE_W-1:0];
				prsfa_pkg::CFG_OFFSET:   offset_q  <= cfg_data[prsfa_pkg::OFF_W-1:0];
				prsfa_pkg::CFG_STOP_PIN: stop_en_q <= cfg_data[0];
				prsfa_pkg::CFG_SETTLE:   settle_q  <= cfg_data[prsfa_pkg::SETTLE_W-1:0];
				default:                 scale_q   <= scale_q;
			endcase
		end
	end

	// Captured word.
	always_ff @(posedge clk) begin
		if (req_take) begin
			item_q <= req_data;
		end
	end

	// Main sequencer with the filter, timer and power-save state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			prev_q        <= '0;
			good_run_q    <= '0;
			sum_q         <= '0;
			count_q       <= '0;
			last_sample_q <= '0;
			last_pulse_q  <= '0;
			dis_start_q   <= '0;
			disabled_q    <= 1'b0;
			pin_q         <= 1'b1;
			last_raw_q    <= '0;
			held_q        <= '0;
			status_q      <= prsfa_pkg::STAT_NO_DATA;
			fresh_q       <= 1'b0;
			rst_q         <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						if (req_data.req_type == prsfa_pkg::REQ_TICK) begin
							state_q <= S_TICK;
						end else if (req_data.sensor_present) begin
							state_q <= S_PWAIT;
						end
					end
				end
				S_PWAIT: begin
					// Filter update once the distance is ready.
					if (dist_done) begin
						last_raw_q   <= item_q.pulse_width_us;
						last_pulse_q <= item_q.now_ms;
						prev_q       <= dist_q8;
						if (jump) begin
							good_run_q <= '0;
						end else if (good_run_q > 2'd1) begin
							if (count_q < prsfa_pkg::CNT_W'(prsfa_pkg::MAX_BATCH)) begin
								count_q <= count_q + 1'b1;
								sum_q   <= sum_q + {{prsfa_pkg::CNT_W{dist_q8[prsfa_pkg::DIST_W-1]}},
									dist_q8};
							end
							last_sample_q <= item_q.pulse_time_us;
						end else begin
							good_run_q <= good_run_q + 2'd1;
						end
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					fresh_q <= 1'b0;
					rst_q   <= 1'b0;
					if (!item_q.sensor_present) begin
						status_q <= prsfa_pkg::STAT_NOT_CONNECTED;
					end else if (powersave) begin
						pin_q      <= 1'b0;
						held_q     <= '0;
						last_raw_q <= '0;
						status_q   <= prsfa_pkg::STAT_NO_DATA;
					end else begin
						if (count_q != '0) begin
							status_q <= prsfa_pkg::STAT_FRESH;
							fresh_q  <= 1'b1;
						end else if (nodata) begin
							status_q <= prsfa_pkg::STAT_NO_DATA;
						end
						// Capture reset after a silent spell; the stop pin drops with it when enabled.
						if (reset_due) begin
							rst_q        <= 1'b1;
							last_pulse_q <= item_q.now_ms;
							if (stop_en_q) begin
								pin_q       <= 1'b0;
								disabled_q  <= 1'b1;
								dis_start_q <= item_q.now_ms;
							end
						end
						// Settle time over: the pin rises again.
						if (settle_due) begin
							pin_q        <= 1'b1;
							disabled_q   <= 1'b0;
							last_pulse_q <= item_q.now_ms;
						end
					end
					sum_q   <= '0;
					count_q <= '0;
					state_q <= avg_start ? S_TDIV : S_TOUT;
				end
				S_TDIV: begin
					if (avg_done) begin
						held_q  <= avg_q8;
						state_q <= S_TOUT;
					end
				end
				S_TOUT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: holds the result until the far side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.distance_q8    <= held_q;
			rsp_q.new_reading    <= fresh_q;
			rsp_q.raw_pulse_us   <= last_raw_q;
			rsp_q.status_code    <= status_q;
			rsp_q.stop_pin_level <= pin_q;
			rsp_q.reset_request  <= rst_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== rtl/core/prsfa_checker.sv =====
// ----------------------------------------------------------------------------
// prsfa_checker
// Checks on the result channel of the range filter, seen at its ports.
// ----------------------------------------------------------------------------
`include "pwm_range_spike_filter_averager_assert.svh"

module prsfa_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input prsfa_pkg::rsp_t rsp_data
);

	// A stalled result stays offered and unchanged.
	`PRSFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
	`PRSFA_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data), "stalled result changed")

	// A new reading always comes with fresh data status.
	`PRSFA_ASSERT_SAME(a_fresh_status, rsp_valid && rsp_data.new_reading, rsp_data.status_code == prsfa_pkg::STAT_FRESH, "new reading without fresh status")

	// While the sensor is reported as not connected, no new reading is flagged.
	`PRSFA_ASSERT_SAME(a_absent_quiet, rsp_valid && (rsp_data.status_code == prsfa_pkg::STAT_NOT_CONNECTED), !rsp_data.new_reading, "absent sensor reported a reading")

endmodule

bind pwm_range_spike_filter_averager prsfa_checker u_prsfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pulse-width range filter and averager. A short
// table of directed words covers reset, sensor loss, saturation, power save,
// the reset and settle timers and stop-pin removal. Random pulse trains with
// ticks follow, under several register settings. Every tick reading is
// compared field by field with a behavioural copy of the filter, or with a
// typed expectation, while the input idles and the result side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT     = 5000;
	localparam int HOLD_OFF_CYCLES    = 600;
	localparam int DRAIN_CYCLES       = 80;
	localparam int RANDOM_PHASE_WORDS = 82;
	localparam longint DIST_MAX = (longint'(1) << (prsfa_pkg::DIST_W - 1)) - 1;
	localparam longint DIST_MIN = -(longint'(1) << (prsfa_pkg::DIST_W - 1));

	typedef enum logic {ROW_WORD, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		prsfa_pkg::req_t    word;
		bit                 typed;
		prsfa_pkg::rsp_t    reading;
		logic [15:0]        scale;
		logic [15:0]        offset;
		logic               pin_enable;
		logic [14:0]        settle;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	prsfa_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	prsfa_pkg::rsp_t rsp_data;
	logic cfg_we;
	logic [prsfa_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [prsfa_pkg::CFG_W-1:0] cfg_data;

	// Register copies held by the filter model.
	logic [prsfa_pkg::SCALE_W-1:0]        scale_reg;
	logic signed [prsfa_pkg::OFF_W-1:0]   offset_reg;
	logic                                 stop_pin_reg;
	logic [prsfa_pkg::SETTLE_W-1:0]       settle_reg;

	// Filter model state.
	logic signed [prsfa_pkg::DIST_W-1:0]  last_distance;
	logic [1:0]                           good_run;
	logic signed [31:0]                   distance_sum;
	logic [5:0]                           batch_count;
	logic [prsfa_pkg::TIME_W-1:0]         last_sample_us;
	logic [prsfa_pkg::TIME_W-1:0]         last_pulse_ms;
	logic [prsfa_pkg::TIME_W-1:0]         disable_start_ms;
	logic                                 sensor_disabled;
	logic                                 pin_level;
	logic                                 saw_pulse;
	logic [prsfa_pkg::PW_W-1:0]           last_raw;
	logic signed [prsfa_pkg::DIST_W-1:0]  held_distance;
	logic [prsfa_pkg::STATUS_W-1:0]       link_status;

	prsfa_pkg::rsp_t pending_readings[$];
	stim_row_t directed_rows[$];

	int mismatches       = 0;
	int words_taken      = 0;
	int effective_words  = 0;
	int readings_checked = 0;
	int fresh_readings   = 0;
	int reset_requests   = 0;
	int idle_cycles      = 0;
	int burst_left       = 1;
	bit hold_done        = 0;

	// Time base of the random pulse trains.
	logic [prsfa_pkg::TIME_W-1:0] track_ms;
	logic [prsfa_pkg::TIME_W-1:0] track_us;
	int track_pw;

	pwm_range_spike_filter_averager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Puts the model into its reset state.
	function automatic void clear_filter_model();
		scale_reg        = prsfa_pkg::SCALE_RESET;
		offset_reg       = '0;
		stop_pin_reg     = 1'b0;
		settle_reg       = '0;
		last_distance    = '0;
		good_run         = '0;
		distance_sum     = '0;
		batch_count      = '0;
		last_sample_us   = '0;
		last_pulse_ms    = '0;
		disable_start_ms = '0;
		sensor_disabled  = 1'b0;
		pin_level        = 1'b1;
		saw_pulse        = 1'b0;
		last_raw         = '0;
		held_distance    = '0;
		link_status      = prsfa_pkg::STAT_NO_DATA;
	endfunction

	// Converts one pulse to a distance and runs it through the spike filter.
	function automatic void filter_pulse(input prsfa_pkg::req_t w);
		longint q;
		longint d;
		longint diff;
		q = (longint'(w.pulse_width_us) * longint'(scale_reg) + prsfa_pkg::ROUND)
			/ prsfa_pkg::DIV_TEN;
		d = q + longint'(offset_reg) * 256;
		if (d > DIST_MAX)
			d = DIST_MAX;
		if (d < DIST_MIN)
			d = DIST_MIN;
		last_raw      = w.pulse_width_us;
		saw_pulse     = 1'b1;
		last_pulse_ms = w.now_ms;
		diff = d - longint'(last_distance);
		if (diff < 0)
			diff = -diff;
		last_distance = d[prsfa_pkg::DIST_W-1:0];
		if (diff > prsfa_pkg::JUMP_Q8) begin
			good_run = '0;
			return;
		end
		if (good_run > 1) begin
			if (batch_count < prsfa_pkg::MAX_BATCH) begin
				batch_count  = batch_count + 6'd1;
				distance_sum = distance_sum + 32'(d);
			end
			last_sample_us = w.pulse_time_us;
		end else begin
			good_run = good_run + 2'd1;
		end
	endfunction

	// Runs the timers and the average of one tick and returns its reading.
	function automatic prsfa_pkg::rsp_t evaluate_tick(input prsfa_pkg::req_t w);
		prsfa_pkg::rsp_t r;
		logic fresh;
		logic rst;
		fresh = 1'b0;
		rst   = 1'b0;
		if (!w.sensor_present) begin
			link_status = prsfa_pkg::STAT_NOT_CONNECTED;
		end else if (stop_pin_reg && w.above_powersave) begin
			pin_level     = 1'b0;
			held_distance = '0;
			last_raw      = '0;
			link_status   = prsfa_pkg::STAT_NO_DATA;
		end else begin
			if (prsfa_pkg::TIME_W'(w.now_us - last_sample_us) >= prsfa_pkg::NODATA_US)
				link_status = prsfa_pkg::STAT_NO_DATA;
			if (prsfa_pkg::TIME_W'(w.now_ms - last_pulse_ms) > prsfa_pkg::RESET_MS
				&& !sensor_disabled) begin
				rst           = 1'b1;
				last_pulse_ms = w.now_ms;
				if (stop_pin_reg) begin
					pin_level        = 1'b0;
					sensor_disabled  = 1'b1;
					disable_start_ms = w.now_ms;
				end
			end
			if (stop_pin_reg && sensor_disabled &&
				prsfa_pkg::TIME_W'(w.now_ms - disable_start_ms)
				> prsfa_pkg::TIME_W'(settle_reg)) begin
				pin_level       = 1'b1;
				sensor_disabled = 1'b0;
				last_pulse_ms   = w.now_ms;
			end
			if (batch_count != 0) begin
				held_distance = prsfa_pkg::DIST_W'(distance_sum / int'(batch_count));
				link_status   = prsfa_pkg::STAT_FRESH;
				fresh         = 1'b1;
			end
		end
		distance_sum = '0;
		batch_count  = '0;
		r.distance_q8    = held_distance;
		r.new_reading    = fresh;
		r.raw_pulse_us   = last_raw;
		r.status_code    = link_status;
		r.stop_pin_level = pin_level;
		r.reset_request  = rst;
		return r;
	endfunction

	function automatic prsfa_pkg::req_t make_word(input logic req, input logic [15:0] pw,
		input logic [31:0] t_us, input logic [31:0] ms, input logic [31:0] us,
		input logic above, input logic present);
		prsfa_pkg::req_t w;
		w.req_type        = req;
		w.pulse_width_us  = pw;
		w.pulse_time_us   = t_us;
		w.now_ms          = ms;
		w.now_us          = us;
		w.above_powersave = above;
		w.sensor_present  = present;
		return w;
	endfunction

	function automatic prsfa_pkg::rsp_t make_reading(input logic signed [23:0] distance,
		input logic fresh, input logic [15:0] raw, input logic [1:0] st, input logic pin,
		input logic rst);
		prsfa_pkg::rsp_t r;
		r.distance_q8    = distance;
		r.new_reading    = fresh;
		r.raw_pulse_us   = raw;
		r.status_code    = st;
		r.stop_pin_level = pin;
		r.reset_request  = rst;
		return r;
	endfunction

	function automatic stim_row_t word_row(input prsfa_pkg::req_t w);
		stim_row_t row;
		row = '{ROW_WORD, w, 1'b0, '0, '0, '0, 1'b0, '0};
		return row;
	endfunction

	function automatic stim_row_t typed_row(input prsfa_pkg::req_t w, input prsfa_pkg::rsp_t r);
		stim_row_t row;
		row = '{ROW_WORD, w, 1'b1, r, '0, '0, 1'b0, '0};
		return row;
	endfunction

	function automatic stim_row_t config_row(input logic [15:0] scale, input logic [15:0] offset,
		input logic pin_enable, input logic [14:0] settle);
		stim_row_t row;
		row = '{ROW_CONFIG, '0, 1'b0, '0, scale, offset, pin_enable, settle};
		return row;
	endfunction

	function automatic void advance_clock(input int ms);
		track_ms = track_ms + ms;
		track_us = track_us + ms * 1000 + $urandom_range(0, 999);
	endfunction

	task automatic report_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// Offers one word, waits for it to be taken and updates the model. A
	// typed reading replaces the model's one as the expectation.
	task automatic send_word(input prsfa_pkg::req_t w, input bit typed,
		input prsfa_pkg::rsp_t typed_reading);
		prsfa_pkg::rsp_t predicted;
		int gap;
		req_data  <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		words_taken++;
		if (w.req_type == prsfa_pkg::REQ_TICK || w.sensor_present)
			effective_words++;
		if (w.req_type == prsfa_pkg::REQ_TICK) begin
			predicted = evaluate_tick(w);
			pending_readings.push_back(typed ? typed_reading : predicted);
		end else if (w.sensor_present) begin
			filter_pulse(w);
		end
		// Bursts of random length, separated by random gaps.
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops offering words and waits until the block has gone quiet.
	task automatic drain_block();
		req_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [prsfa_pkg::CFG_IDX_W-1:0] idx,
		input logic [prsfa_pkg::CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			prsfa_pkg::CFG_SCALE:    scale_reg    = data;
			prsfa_pkg::CFG_OFFSET:   offset_reg   = data;
			prsfa_pkg::CFG_STOP_PIN: stop_pin_reg = data[0];
			prsfa_pkg::CFG_SETTLE:   settle_reg   = data[prsfa_pkg::SETTLE_W-1:0];
			default: ;
		endcase
	endtask

	// Writes all four registers while the block is idle. Unused upper bits
	// carry random values, as the block ignores them.
	task automatic apply_config(input logic [15:0] scale, input logic [15:0] offset,
		input logic pin_enable, input logic [14:0] settle);
		drain_block();
		write_reg(prsfa_pkg::CFG_SCALE, scale);
		write_reg(prsfa_pkg::CFG_OFFSET, offset);
		write_reg(prsfa_pkg::CFG_STOP_PIN, {15'($urandom), pin_enable});
		write_reg(prsfa_pkg::CFG_SETTLE, {1'($urandom), settle});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly pulse trains of agreeing widths closed by a tick, with spikes,
	// silences, power save, sensor loss and fully random words mixed in.
	task automatic run_random_phase(input int quota);
		int target;
		int n_pulses;
		int jitter;
		int pw_i;
		target = effective_words + quota;
		while (effective_words < target) begin
			if ($urandom_range(0, 9) == 0) begin
				send_word(make_word(1'($urandom_range(0, 1)), 16'($urandom), $urandom,
					$urandom, $urandom, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))), 1'b0, '0);
			end else begin
				if ($urandom_range(0, 3) == 0)
					track_pw = $urandom_range(50, 30000);
				n_pulses = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40)
					: $urandom_range(0, 8);
				repeat (n_pulses) begin
					advance_clock($urandom_range(10, 60));
					jitter = $urandom_range(0, 40);
					if ($urandom_range(0, 19) == 0)
						pw_i = $urandom_range(0, 65535);
					else
						pw_i = track_pw + jitter - 20;
					send_word(make_word(prsfa_pkg::REQ_PULSE, pw_i[15:0],
						track_us - $urandom_range(0, 500), track_ms, track_us,
						1'($urandom_range(0, 1)), $urandom_range(0, 29) != 0),
						1'b0, '0);
				end
				if ($urandom_range(0, 5) == 0)
					advance_clock($urandom_range(150, 3000));
				else if ($urandom_range(0, 19) == 0)
					advance_clock($urandom_range(30000, 40000));
				else
					advance_clock($urandom_range(5, 40));
				send_word(make_word(prsfa_pkg::REQ_TICK, 16'($urandom), $urandom, track_ms,
					track_us, $urandom_range(0, 7) == 0, $urandom_range(0, 19) != 0),
					1'b0, '0);
			end
		end
	endtask

	// Main sequence: reset, directed table, then random phases.
	initial begin
		req_valid <= 1'b0;
		req_data  <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= prsfa_pkg::CFG_SCALE;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		clear_filter_model();
		track_ms = $urandom;
		track_us = $urandom;
		track_pw = 3000;

		// Reset state, sensor loss, then a plain batch of two samples.
		directed_rows.push_back(typed_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd0,
			32'd0, 1'b0, 1'b1), make_reading(24'sd0, 1'b0, 16'd0, prsfa_pkg::STAT_NO_DATA,
			1'b1, 1'b0)));
		directed_rows.push_back(typed_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd0,
			32'd0, 1'b0, 1'b0), make_reading(24'sd0, 1'b0, 16'd0,
			prsfa_pkg::STAT_NOT_CONNECTED, 1'b1, 1'b0)));
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_PULSE, 16'hFFFF, 32'd1000,
			32'd10, 32'd0, 1'b0, 1'b0)));
		repeat (3)
			directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_PULSE, 16'd0, 32'd1000,
				32'd10, 32'd0, 1'b0, 1'b1)));
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_PULSE, 16'd100, 32'd1000,
			32'd10, 32'd0, 1'b0, 1'b1)));
		directed_rows.push_back(typed_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd10,
			32'd2000, 1'b0, 1'b1), make_reading(24'sd3840, 1'b1, 16'd100,
			prsfa_pkg::STAT_FRESH, 1'b1, 1'b0)));
		// A spike, the no-data timer and a reset request without a stop pin.
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_PULSE, 16'hFFFF,
			32'hFFFF_FFFF, 32'd10, 32'd0, 1'b0, 1'b1)));
		directed_rows.push_back(typed_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd10,
			32'd201000, 1'b0, 1'b1), make_reading(24'sd3840, 1'b0, 16'hFFFF,
			prsfa_pkg::STAT_NO_DATA, 1'b1, 1'b0)));
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd511,
			32'd201000, 1'b0, 1'b1)));
		// Largest scale and offset saturate the distance, then power save.
		directed_rows.push_back(config_row(16'hFFFF, 16'h7FFF, 1'b1, 15'd0));
		repeat (4)
			directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_PULSE, 16'hFFFF,
				32'd300000, 32'd520, 32'd0, 1'b0, 1'b1)));
		directed_rows.push_back(typed_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd520,
			32'd300100, 1'b1, 1'b1), make_reading(24'sd0, 1'b0, 16'd0,
			prsfa_pkg::STAT_NO_DATA, 1'b0, 1'b0)));
		// Reset with a stop pin, then settle on the next millisecond.
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd1100,
			32'd300200, 1'b0, 1'b1)));
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd1101,
			32'd300300, 1'b0, 1'b1)));
		// Smallest scale and offset, longest settle, stop pin removed while disabled.
		directed_rows.push_back(config_row(16'd0, 16'h8000, 1'b1, 15'h7FFF));
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_PULSE, 16'd12345, 32'd400000,
			32'd1200, 32'd0, 1'b0, 1'b1)));
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd1800,
			32'd400100, 1'b0, 1'b1)));
		directed_rows.push_back(config_row(16'd0, 16'h8000, 1'b0, 15'h7FFF));
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd50000,
			32'd500000, 1'b0, 1'b1)));
		directed_rows.push_back(config_row(16'd0, 16'h8000, 1'b1, 15'h7FFF));
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_TICK, 16'd0, 32'd0, 32'd50001,
			32'd500100, 1'b0, 1'b1)));
		// Millisecond counter wrapped behind the last pulse.
		directed_rows.push_back(word_row(make_word(prsfa_pkg::REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF,
			32'h100, 32'hFFFF_FFFF, 1'b0, 1'b1)));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG)
				apply_config(directed_rows[i].scale, directed_rows[i].offset,
					directed_rows[i].pin_enable, directed_rows[i].settle);
			else
				send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].reading);
		end

		// Random phases under a spread of register settings, extremes included.
		apply_config(prsfa_pkg::SCALE_RESET, 16'd0, 1'b0, 15'd0);
		run_random_phase(RANDOM_PHASE_WORDS);
		apply_config(16'hFFFF, 16'h7FFF, 1'b1, 15'h7FFF);
		run_random_phase(RANDOM_PHASE_WORDS);
		apply_config(16'd0, 16'h8000, 1'b1, 15'd0);
		run_random_phase(RANDOM_PHASE_WORDS);
		apply_config(16'($urandom_range(256, 4096)), 16'($urandom_range(0, 400) - 200), 1'b1,
			15'($urandom_range(0, 2000)));
		run_random_phase(RANDOM_PHASE_WORDS);
		apply_config(prsfa_pkg::SCALE_RESET, 16'($urandom), 1'b0, 15'($urandom));
		run_random_phase(RANDOM_PHASE_WORDS);
		apply_config(16'($urandom_range(256, 4096)), 16'($urandom), 1'($urandom_range(0, 1)),
			15'($urandom_range(0, 100)));
		run_random_phase(RANDOM_PHASE_WORDS);

		drain_block();
		$display("Covered %0d words, %0d tick readings checked, %0d averaged, %0d reset requests.",
			words_taken, readings_checked, fresh_readings, reset_requests);
		$display("Settings ran from the smallest to the largest scale, offset and settle time.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: stall segments of random style and length, and one long
	// hold-off so that the block backs up into its input.
	initial begin : stall_readings
		int mode;
		int len;
		int step;
		logic [15:0] pattern;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && readings_checked >= 30) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			mode    = $urandom_range(0, 3);
			len     = $urandom_range(16, 80);
			pattern = $urandom;
			for (step = 0; step < len; step++) begin
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= 1'($urandom_range(0, 1));
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= pattern[step % 16];
				endcase
				@(posedge clk);
			end
		end
	end

	// Compares each accepted reading with the oldest one waiting.
	always @(posedge clk) begin : check_readings
		prsfa_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_readings.size() == 0) begin
				report_error($sformatf("reading %h arrived with no tick waiting", rsp_data));
			end else begin
				want = pending_readings.pop_front();
				readings_checked++;
				if (want.new_reading)
					fresh_readings++;
				if (want.reset_request)
					reset_requests++;
				if (rsp_data.distance_q8 !== want.distance_q8)
					report_error($sformatf("distance_q8 expected %0d, got %0d",
						want.distance_q8, rsp_data.distance_q8));
				if (rsp_data.new_reading !== want.new_reading)
					report_error($sformatf("new_reading expected %0b, got %0b",
						want.new_reading, rsp_data.new_reading));
				if (rsp_data.raw_pulse_us !== want.raw_pulse_us)
					report_error($sformatf("raw_pulse_us expected %0d, got %0d",
						want.raw_pulse_us, rsp_data.raw_pulse_us));
				if (rsp_data.status_code !== want.status_code)
					report_error($sformatf("status_code expected %0d, got %0d",
						want.status_code, rsp_data.status_code));
				if (rsp_data.stop_pin_level !== want.stop_pin_level)
					report_error($sformatf("stop_pin_level expected %0b, got %0b",
						want.stop_pin_level, rsp_data.stop_pin_level));
				if (rsp_data.reset_request !== want.reset_request)
					report_error($sformatf("reset_request expected %0b, got %0b",
						want.reset_request, rsp_data.reset_request));
			end
		end
	end

	// Ends the run when no word moves on either side for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d cycles without a word, %0d readings still waiting.",
				idle_cycles, pending_readings.size());
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
